// ----- src/rcmae_pkg.sv -----
// Shared types and constants for the mode activation evaluator.
`default_nettype none

package rcmae_pkg;

  // Request kinds carried on s_tuser
  localparam logic [1:0] OP_WR_COND = 2'd0;
  localparam logic [1:0] OP_WR_AUX  = 2'd1;
  localparam logic [1:0] OP_EVAL    = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_AIRMODE_FEATURE = 2'd0;
  localparam logic [1:0] CFG_STICKY_ID       = 2'd1;
  localparam logic [1:0] CFG_AIRMODE_ID      = 2'd2;
  localparam logic [1:0] CFG_SELECT_COUNT    = 2'd3;

  // Pulse width range and step size in microseconds
  localparam logic [11:0] PULSE_MIN = 12'd900;
  localparam logic [11:0] PULSE_MAX = 12'd2099;
  localparam logic [11:0] STEP_US   = 12'd25;

  typedef struct packed {
    logic [5:0] mode;
    logic [3:0] aux;
    logic [5:0] start_step;
    logic [5:0] end_step;
    logic       logic_and;
    logic [5:0] link;
  } cond_t;

  typedef struct packed {
    logic valid;
    logic pass2;
    logic boot_done;
  } step_t;

  typedef struct packed {
    logic [5:0] sticky_id;
    logic [6:0] select_count;
  } eval_cfg_t;

endpackage

`default_nettype wire

// ----- src/rcmae_cond_mem.sv -----
// Condition table: synchronous memory with per-entry valid bits.
`default_nettype none

module rcmae_cond_mem
  import rcmae_pkg::*;
#(
  parameter int CONDITION_SLOTS = 20,
  localparam int AW = (CONDITION_SLOTS > 1) ? $clog2(CONDITION_SLOTS) : 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire cond_t         wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output cond_t              rdata
);

  cond_t                      mem [CONDITION_SLOTS];
  logic [CONDITION_SLOTS-1:0] valid;
  cond_t                      rd_q;
  logic                       rd_valid;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (we) begin
        valid[waddr] <= 1'b1;
      end
      if (re) begin
        rd_valid <= valid[raddr];
      end
    end
  end

  // Entry never written reads as empty
  assign rdata = rd_valid ? rd_q : '0;

endmodule

`default_nettype wire

// ----- src/rcmae_aux_mem.sv -----
// Aux channel values: synchronous memory with per-entry valid bits.
`default_nettype none

module rcmae_aux_mem
  import rcmae_pkg::*;
#(
  parameter int AUX_CHANNELS = 16,
  localparam int AW = (AUX_CHANNELS > 1) ? $clog2(AUX_CHANNELS) : 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [11:0]   wdata,
  input  wire logic          re,
  input  wire logic [3:0]    rsel,
  output logic [11:0]        rdata
);

  logic [11:0]             mem [AUX_CHANNELS];
  logic [AUX_CHANNELS-1:0] valid;
  logic [11:0]             rd_q;
  logic                    rd_hit;
  logic [5:0]              rsel_ext;
  logic                    rsel_ok;
  logic [AW-1:0]           ridx;

  assign rsel_ext = {2'b00, rsel};
  assign rsel_ok  = rsel_ext < 6'(AUX_CHANNELS);
  assign ridx     = rsel_ext[AW-1:0];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re && rsel_ok) begin
      rd_q <= mem[ridx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rd_hit <= 1'b0;
    end else begin
      if (we) begin
        valid[waddr] <= 1'b1;
      end
      if (re) begin
        rd_hit <= rsel_ok && valid[ridx];
      end
    end
  end

  // Missing channel or unwritten entry reads as zero
  assign rdata = rd_hit ? rd_q : 12'd0;

endmodule

`default_nettype wire

// ----- src/rcmae_apply.sv -----
// Per-condition evaluation and the AND/OR mode accumulators.
`default_nettype none

module rcmae_apply
  import rcmae_pkg::*;
#(
  parameter int MODE_COUNT = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic        commit,
  input  wire step_t       step,
  input  wire cond_t       cond,
  input  wire logic [11:0] aux_value,
  input  wire eval_cfg_t   cfg,
  output logic [63:0]      mask_next,
  output logic [63:0]      mode_mask
);

  localparam logic [63:0] LIMIT =
    (MODE_COUNT >= 64) ? {64{1'b1}} : ((64'd1 << MODE_COUNT) - 64'd1);

  logic [63:0] and_m, new_m, and_next, new_next, bit_m;
  logic        seen_off, set_seen;
  logic [11:0] v, lo, hi;
  logic        range_act, link_act, act, do_apply, force_on;
  logic        is_empty, mode_ok, link_ok;

  always_comb begin
    v = aux_value;
    if (v < PULSE_MIN) v = PULSE_MIN;
    if (v > PULSE_MAX) v = PULSE_MAX;
    lo = PULSE_MIN + STEP_US * {6'd0, cond.start_step};
    hi = PULSE_MIN + STEP_US * {6'd0, cond.end_step};
  end

  assign range_act = (cond.start_step < cond.end_step) && (v >= lo) && (v < hi);
  assign is_empty  = ~|{cond.mode, cond.aux, cond.start_step, cond.end_step,
                        cond.logic_and};
  assign mode_ok   = {1'b0, cond.mode} < 7'(MODE_COUNT);
  assign link_ok   = {1'b0, cond.link} < 7'(MODE_COUNT);
  assign link_act  = link_ok && (and_m[cond.link] ^ new_m[cond.link]);
  assign bit_m     = 64'd1 << cond.mode;

  always_comb begin
    do_apply = 1'b0;
    force_on = 1'b0;
    set_seen = 1'b0;
    act      = range_act;
    if (step.valid) begin
      if (!step.pass2) begin
        if (cond.link == 6'd0 && !is_empty && mode_ok) begin
          if (cond.mode == cfg.sticky_id) begin
            // Sticky mode: hold on once active, arm only after seen off
            if (mode_mask[cond.mode]) begin
              force_on = 1'b1;
            end else if (seen_off) begin
              do_apply = 1'b1;
            end else if (step.boot_done && !range_act) begin
              set_seen = 1'b1;
            end
          end else if ({1'b0, cond.mode} < cfg.select_count) begin
            do_apply = 1'b1;
          end
        end
      end else if (cond.link != 6'd0 && mode_ok) begin
        do_apply = 1'b1;
        act      = link_act;
      end
    end

    and_next = and_m;
    new_next = new_m;
    if (force_on) begin
      and_next = and_m & ~bit_m;
      new_next = new_m | bit_m;
    end else if (do_apply && ((and_m & bit_m) != 64'd0 || (new_m & bit_m) == 64'd0)) begin
      if (!cond.logic_and) begin
        if (act) begin
          and_next = and_m & ~bit_m;
          new_next = new_m | bit_m;
        end
      end else begin
        and_next = and_m | bit_m;
        if (!act) new_next = new_m | bit_m;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      and_m     <= '0;
      new_m     <= '0;
      seen_off  <= 1'b0;
      mode_mask <= '0;
    end else begin
      if (start) begin
        and_m <= '0;
        new_m <= '0;
      end else begin
        and_m <= and_next;
        new_m <= new_next;
      end
      if (set_seen) seen_off <= 1'b1;
      if (commit) mode_mask <= mask_next;
    end
  end

  assign mask_next = (new_m ^ and_m) & LIMIT;

endmodule

`default_nettype wire

// ----- src/rc_mode_activation_evaluator_core.sv -----
// Top level of the mode activation evaluator: stream ports, sequencer, result register.
//
//  Port group | Dir | Width  | Carries
//  s_*        | in  | 48 / 2 | condition write, aux write or evaluate request
//  m_*        | out | 72     | active mode mask and airmode flag (evaluate only)
//  cfg_*      | in  | 7      | register writes, no read-back
//
// An evaluate request runs the sequencer, which issues one condition-memory
// read per cycle over both passes; each read passes through the condition
// read and then the aux read before the update stage.
// Reset clears all tables through valid bits; no sweep is needed.
// A waiting result does not block new requests until the next evaluate ends.
`default_nettype none

module rc_mode_activation_evaluator_core
  import rcmae_pkg::*;
#(
  parameter int CONDITION_SLOTS = 20,
  parameter int MODE_COUNT      = 64,
  parameter int AUX_CHANNELS    = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // slot[4:0] mode_number[10:5] aux_select[14:11] start_step[20:15]
  // end_step[26:21] logic_and[27] linked_mode[33:28] channel_value[45:34]
  // boot_done[46] zero[47]
  input  wire logic [47:0] s_tdata,
  input  wire logic [1:0]  s_tuser,   // operation[1:0]
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // active_modes[63:0] airmode_on[64] zero[71:65]
  output logic [71:0]      m_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [6:0]  cfg_data
);

  localparam int CW = (CONDITION_SLOTS > 1) ? $clog2(CONDITION_SLOTS) : 1;
  localparam int XW = (AUX_CHANNELS > 1) ? $clog2(AUX_CHANNELS) : 1;
  localparam logic [63:0] LIMIT =
    (MODE_COUNT >= 64) ? {64{1'b1}} : ((64'd1 << MODE_COUNT) - 64'd1);

  typedef enum logic [1:0] {S_IDLE, S_EVAL, S_DONE} state_t;

  state_t      state;
  logic [CW-1:0] idx;
  logic        pass2, issue_on, boot_q;
  step_t       s1, s2;
  logic        s1_last, s2_last;
  cond_t       cond_rd, cond_s2;
  logic [11:0] aux_rd;

  logic        airmode_feature;
  logic [5:0]  sticky_mode_id, airmode_mode_id;
  logic [6:0]  selectable_mode_count;

  logic        accept, commit, start, cond_we, aux_we, rd_en, idx_end, airmode_next;
  logic [6:0]  slot_ext;
  cond_t       cond_wr;
  eval_cfg_t   ecfg;
  logic [63:0] mask_next, mode_mask;

  // Unpack the request
  assign slot_ext = {2'b00, s_tdata[4:0]};
  assign cond_wr  = '{mode: s_tdata[10:5], aux: s_tdata[14:11],
                      start_step: s_tdata[20:15], end_step: s_tdata[26:21],
                      logic_and: s_tdata[27], link: s_tdata[33:28]};

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign cond_we  = accept && s_tuser == OP_WR_COND && slot_ext < 7'(CONDITION_SLOTS);
  assign aux_we   = accept && s_tuser == OP_WR_AUX && slot_ext < 7'(AUX_CHANNELS);
  assign start    = accept && s_tuser == OP_EVAL;
  assign rd_en    = (state == S_EVAL) && issue_on;
  assign idx_end  = idx == CW'(CONDITION_SLOTS - 1);
  assign commit   = (state == S_DONE) && (!m_tvalid || m_tready);

  assign ecfg         = '{sticky_id: sticky_mode_id, select_count: selectable_mode_count};
  assign airmode_next = airmode_feature || mask_next[airmode_mode_id];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      airmode_feature       <= 1'b0;
      sticky_mode_id        <= 6'd0;
      airmode_mode_id       <= 6'd0;
      selectable_mode_count <= 7'd64;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_AIRMODE_FEATURE: airmode_feature       <= cfg_data[0];
        CFG_STICKY_ID:       sticky_mode_id        <= cfg_data[5:0];
        CFG_AIRMODE_ID:      airmode_mode_id       <= cfg_data[5:0];
        CFG_SELECT_COUNT:    selectable_mode_count <= cfg_data;
        default: ;
      endcase
    end
  end

  rcmae_cond_mem #(.CONDITION_SLOTS(CONDITION_SLOTS)) u_cond_mem (
    .clk   (clk),
    .rst   (rst),
    .we    (cond_we),
    .waddr (slot_ext[CW-1:0]),
    .wdata (cond_wr),
    .re    (rd_en),
    .raddr (idx),
    .rdata (cond_rd)
  );

  // Aux read is addressed by the condition just read
  rcmae_aux_mem #(.AUX_CHANNELS(AUX_CHANNELS)) u_aux_mem (
    .clk   (clk),
    .rst   (rst),
    .we    (aux_we),
    .waddr (slot_ext[XW-1:0]),
    .wdata (s_tdata[45:34]),
    .re    (s1.valid),
    .rsel  (cond_rd.aux),
    .rdata (aux_rd)
  );

  rcmae_apply #(.MODE_COUNT(MODE_COUNT)) u_apply (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .commit    (commit),
    .step      (s2),
    .cond      (cond_s2),
    .aux_value (aux_rd),
    .cfg       (ecfg),
    .mask_next (mask_next),
    .mode_mask (mode_mask)
  );

  // Sequencer, pipeline tags and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      idx      <= '0;
      pass2    <= 1'b0;
      issue_on <= 1'b0;
      boot_q   <= 1'b0;
      s1       <= '0;
      s2       <= '0;
      s1_last  <= 1'b0;
      s2_last  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      // Advance the read pipeline every cycle
      s1      <= '{valid: rd_en, pass2: pass2, boot_done: boot_q};
      s1_last <= pass2 && idx_end;
      s2      <= s1;
      s2_last <= s1_last;
      cond_s2 <= cond_rd;

      // Load a new result, or drop the one just taken
      if (commit) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (start) begin
            state    <= S_EVAL;
            idx      <= '0;
            pass2    <= 1'b0;
            issue_on <= 1'b1;
            boot_q   <= s_tdata[46];
          end
        end
        S_EVAL: begin
          if (issue_on) begin
            if (idx_end) begin
              idx <= '0;
              if (pass2) issue_on <= 1'b0;
              pass2 <= 1'b1;
            end else begin
              idx <= idx + CW'(1);
            end
          end
          if (s2.valid && s2_last) state <= S_DONE;
        end
        S_DONE: begin
          // Hold until the result register is free
          if (commit) begin
            m_tdata  <= {7'd0, airmode_next, mask_next};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_idle_drained: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !s1.valid && !s2.valid)
    else $error("request taken while evaluation pipeline busy");

  a_commit_loads: assert property (@(posedge clk) disable iff (rst)
    commit |=> m_tvalid)
    else $error("committed result not presented");

  a_mask_limit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[63:0] & ~LIMIT) == 64'd0) && (m_tdata[71:65] == 7'd0))
    else $error("mode bit beyond mode count set");

  a_eval_blocks: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser == OP_EVAL) |=> !s_tready)
    else $error("evaluate request did not start the sequencer");

  a_result_is_mask: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[63:0] == mode_mask))
    else $error("presented result differs from held mode mask");

endmodule

`default_nettype wire

// ----- tb/sv/rcmae_mode_checker.sv -----
// Scoreboard for the mode activation evaluator: request tracking, mode prediction, result compare.
`default_nettype none

module rcmae_mode_checker
  import rcmae_pkg::*;
#(
  parameter int CONDITION_SLOTS = 20,
  parameter int MODE_COUNT      = 64,
  parameter int AUX_CHANNELS    = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [47:0] s_tdata,
  input  wire logic [1:0]  s_tuser,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [71:0] m_tdata,
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [6:0]  cfg_data,
  output int               fail_count,
  output int               pending
);

  localparam int XW = (AUX_CHANNELS > 1) ? $clog2(AUX_CHANNELS) : 1;

  typedef struct packed {
    logic        pad;
    logic        boot_done;
    logic [11:0] channel_value;
    logic [5:0]  linked_mode;
    logic        logic_and;
    logic [5:0]  end_step;
    logic [5:0]  start_step;
    logic [3:0]  aux_select;
    logic [5:0]  mode_number;
    logic [4:0]  slot;
  } request_t;

  typedef struct packed {
    logic        air;
    logic [63:0] modes;
  } mode_result_t;

  cond_t        cond_tab [CONDITION_SLOTS];
  logic [11:0]  aux_val [AUX_CHANNELS];
  logic [63:0]  mask_q;
  logic         seen_off;
  logic         air_feature;
  logic [5:0]   sticky_id;
  logic [5:0]   air_id;
  logic [6:0]   sel_count;
  // running AND-membership and hit sets of one evaluate
  logic [63:0]  and_set;
  logic [63:0]  hit_set;
  mode_result_t modes_due [$];
  int           errors = 0;

  function automatic logic range_hit(cond_t c);
    int unsigned v;
    int unsigned lo;
    int unsigned hi;
    if (c.start_step >= c.end_step)
      return 1'b0;
    v = (c.aux < AUX_CHANNELS) ? 32'(aux_val[c.aux]) : 32'd0;
    if (v < 32'(PULSE_MIN))
      v = 32'(PULSE_MIN);
    if (v > 32'(PULSE_MAX))
      v = 32'(PULSE_MAX);
    lo = 32'(PULSE_MIN) + 32'(STEP_US) * 32'(c.start_step);
    hi = 32'(PULSE_MIN) + 32'(STEP_US) * 32'(c.end_step);
    return (v >= lo) && (v < hi);
  endfunction

  // Merge one condition outcome into the AND/OR sets of its mode.
  function automatic void fold(cond_t c, logic act);
    logic [63:0] b;
    b = 64'd1 << c.mode;
    if ((and_set & b) != 0 || (hit_set & b) == 0) begin
      if (!c.logic_and) begin
        if (act) begin
          and_set &= ~b;
          hit_set |= b;
        end
      end else begin
        and_set |= b;
        if (!act)
          hit_set |= b;
      end
    end
  endfunction

  function automatic mode_result_t evaluate(logic boot);
    cond_t        c;
    logic [63:0]  b;
    logic [63:0]  limit;
    logic         act;
    mode_result_t r;
    int           i;
    and_set = '0;
    hit_set = '0;
    // unlinked conditions test their aux channel
    for (i = 0; i < CONDITION_SLOTS; i++) begin
      c = cond_tab[i];
      if (c.link == 0 && c != '0 && c.mode < MODE_COUNT) begin
        b = 64'd1 << c.mode;
        if (c.mode == sticky_id) begin
          if ((mask_q & b) != 0) begin
            and_set &= ~b;
            hit_set |= b;
          end else begin
            act = range_hit(c);
            if (seen_off)
              fold(c, act);
            else if (boot && !act)
              seen_off = 1'b1;
          end
        end else if (c.mode < sel_count) begin
          fold(c, range_hit(c));
        end
      end
    end
    // linked conditions follow the current state of their linked mode
    for (i = 0; i < CONDITION_SLOTS; i++) begin
      c = cond_tab[i];
      if (c.link != 0 && c.mode < MODE_COUNT) begin
        act = (c.link < MODE_COUNT) && (and_set[c.link] != hit_set[c.link]);
        fold(c, act);
      end
    end
    limit = '1;
    if (MODE_COUNT < 64)
      limit = (64'd1 << MODE_COUNT) - 64'd1;
    mask_q = (hit_set ^ and_set) & limit;
    r.modes = mask_q;
    r.air = air_feature | mask_q[air_id];
    return r;
  endfunction

  always @(posedge clk) begin
    request_t     req;
    mode_result_t want;
    int           i;
    if (rst) begin
      for (i = 0; i < CONDITION_SLOTS; i++)
        cond_tab[i] = '0;
      for (i = 0; i < AUX_CHANNELS; i++)
        aux_val[i] = '0;
      mask_q = '0;
      seen_off = 1'b0;
      air_feature = 1'b0;
      sticky_id = '0;
      air_id = '0;
      sel_count = 7'd64;
      modes_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_AIRMODE_FEATURE: air_feature = cfg_data[0];
          CFG_STICKY_ID:       sticky_id = cfg_data[5:0];
          CFG_AIRMODE_ID:      air_id = cfg_data[5:0];
          CFG_SELECT_COUNT:    sel_count = cfg_data;
          default: ;
        endcase
      end
      // results first, so a stray one never pairs with a request of this edge
      if (m_tvalid && m_tready) begin
        if (modes_due.size() == 0) begin
          errors++;
          $display("%0t: result with none outstanding, got %h", $time, m_tdata);
        end else begin
          want = modes_due.pop_front();
          if (m_tdata[63:0] !== want.modes) begin
            errors++;
            $display("%0t: active_modes expected %h, got %h",
                     $time, want.modes, m_tdata[63:0]);
          end
          if (m_tdata[64] !== want.air) begin
            errors++;
            $display("%0t: airmode_on expected %b, got %b", $time, want.air, m_tdata[64]);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        req = s_tdata;
        case (s_tuser)
          OP_WR_COND: begin
            if (req.slot < CONDITION_SLOTS) begin
              cond_tab[req.slot].mode = req.mode_number;
              cond_tab[req.slot].aux = req.aux_select;
              cond_tab[req.slot].start_step = req.start_step;
              cond_tab[req.slot].end_step = req.end_step;
              cond_tab[req.slot].logic_and = req.logic_and;
              cond_tab[req.slot].link = req.linked_mode;
            end
          end
          OP_WR_AUX: begin
            if (req.slot < AUX_CHANNELS)
              aux_val[req.slot[XW-1:0]] = req.channel_value;
          end
          OP_EVAL: modes_due.push_back(evaluate(req.boot_done));
          default: ;
        endcase
      end
    end
    fail_count <= errors;
    pending <= modes_due.size();
  end

endmodule

`default_nettype wire

// ----- tb/sv/rc_mode_activation_evaluator_core_tb.sv -----
// Testbench top for the mode activation evaluator: clock, reset, request stimulus, verdict.
`default_nettype none

module rc_mode_activation_evaluator_core_tb;
  import rcmae_pkg::*;

  // Spare request kind: the block must ignore it
  localparam logic [1:0] OP_NOP = 2'd3;
  // Long output stall that forces the block to back-pressure its input
  localparam int RX_HOLD_CYCLES = 400;
  // Idle time before a register write: one full evaluate plus margin
  localparam int SETTLE_CYCLES  = 48;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 200;

  logic        clk;
  logic        rst = 1'b1;
  logic [47:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] m_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [6:0]  cfg_data = '0;
  int          fail_count;
  int          pending;

  // Stimulus knobs shared with the result sink
  logic        hold_rx = 1'b0;
  logic        calm = 1'b0;
  // Modes and aux channels that random conditions cluster on per phase
  logic [5:0]  mode_pool [6];
  logic [3:0]  aux_pool [4];

  rc_mode_activation_evaluator_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  rcmae_mode_checker mode_check (
    .clk        (clk),
    .rst        (rst),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .m_tdata    (m_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Idle length: mostly none or short, now and then long; none in calm phases
  function automatic int idle_len();
    int r;
    if (calm)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 85)
      return $urandom_range(1, 3);
    if (r < 97)
      return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Pack request fields, first field in the low bits, top bit zero
  function automatic logic [47:0] req_word(logic [4:0] slot, logic [5:0] mode,
                                           logic [3:0] aux, logic [5:0] st,
                                           logic [5:0] en, logic la, logic [5:0] link,
                                           logic [11:0] val, logic boot);
    return {1'b0, boot, val, link, la, en, st, aux, mode, slot};
  endfunction

  // Offer one request from a falling edge, hold it until taken, then maybe idle
  task automatic send(input logic [1:0] op, input logic [47:0] data);
    int gap;
    s_tuser <= op;
    s_tdata <= data;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready)
      @(posedge clk);
    @(negedge clk);
    gap = idle_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Fields a request kind does not use carry random junk
  task automatic put_cond(input logic [4:0] slot, input logic [5:0] mode,
                          input logic [3:0] aux, input logic [5:0] st, input logic [5:0] en,
                          input logic la, input logic [5:0] link);
    send(OP_WR_COND, req_word(slot, mode, aux, st, en, la, link,
                              12'($urandom_range(0, 4095)), 1'($urandom_range(0, 1))));
  endtask

  task automatic put_aux(input logic [4:0] ch, input logic [11:0] val);
    send(OP_WR_AUX, req_word(ch, 6'($urandom_range(0, 63)), 4'($urandom_range(0, 15)),
                             6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                             1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)), val,
                             1'($urandom_range(0, 1))));
  endtask

  task automatic put_eval(input logic boot);
    send(OP_EVAL, req_word(5'($urandom_range(0, 31)), 6'($urandom_range(0, 63)),
                           4'($urandom_range(0, 15)), 6'($urandom_range(0, 63)),
                           6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)),
                           6'($urandom_range(0, 63)), 12'($urandom_range(0, 4095)), boot));
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_config(input logic feat, input logic [5:0] sticky,
                            input logic [5:0] air, input logic [6:0] count);
    write_reg(CFG_AIRMODE_FEATURE, {6'd0, feat});
    write_reg(CFG_STICKY_ID, {1'b0, sticky});
    write_reg(CFG_AIRMODE_ID, {1'b0, air});
    write_reg(CFG_SELECT_COUNT, count);
  endtask

  // Stop offering, wait out every outstanding result, then let the block settle
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [5:0] pick_mode();
    if ($urandom_range(0, 99) < 85)
      return mode_pool[$urandom_range(0, 5)];
    return 6'($urandom_range(0, 63));
  endfunction

  // One random request, weighted toward condition/aux updates that matter
  task automatic random_item();
    int          r;
    int          k;
    logic [4:0]  slot;
    logic [5:0]  st;
    logic [5:0]  en;
    logic [5:0]  link;
    logic [3:0]  aux;
    logic [11:0] val;
    r = $urandom_range(0, 99);
    if (r < 25) begin
      slot = ($urandom_range(0, 9) != 0) ? 5'($urandom_range(0, 19))
                                         : 5'($urandom_range(0, 31));
      if ($urandom_range(0, 9) == 0) begin
        // clear the slot back to an empty condition
        put_cond(slot, 6'd0, 4'd0, 6'd0, 6'd0, 1'b0, 6'd0);
      end else begin
        k = $urandom_range(0, 99);
        if (k < 70) begin
          st = 6'($urandom_range(0, 47));
          en = 6'($urandom_range(st + 1, 48));
        end else if (k < 85) begin
          en = 6'($urandom_range(0, 48));
          st = 6'($urandom_range(en, 48));
        end else begin
          st = 6'($urandom_range(0, 63));
          en = 6'($urandom_range(0, 63));
        end
        k = $urandom_range(0, 99);
        if (k < 65)
          link = 6'd0;
        else if (k < 95)
          link = mode_pool[$urandom_range(0, 5)];
        else
          link = 6'($urandom_range(0, 63));
        aux = ($urandom_range(0, 4) != 0) ? aux_pool[$urandom_range(0, 3)]
                                          : 4'($urandom_range(0, 15));
        put_cond(slot, pick_mode(), aux, st, en, 1'($urandom_range(0, 1)), link);
      end
    end else if (r < 60) begin
      slot = ($urandom_range(0, 19) < 17) ? {1'b0, aux_pool[$urandom_range(0, 3)]}
                                          : 5'($urandom_range(0, 31));
      k = $urandom_range(0, 99);
      if (k < 50)
        val = 12'(900 + 25 * $urandom_range(0, 48) + $urandom_range(0, 2) - 1);
      else if (k < 70)
        val = 12'($urandom_range(0, 4095));
      else if (k < 85)
        val = 12'($urandom_range(0, 899));
      else
        val = 12'($urandom_range(2099, 4095));
      put_aux(slot, val);
    end else if (r < 96) begin
      put_eval($urandom_range(0, 3) != 0);
    end else begin
      send(OP_NOP, {1'b0, 47'($urandom()) ^ (47'($urandom()) << 32)});
    end
  endtask

  // Result sink: random short stalls, an occasional long one, and a long
  // hold-off on request so that the block backs up into its input.
  initial begin : result_sink
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_rx) begin
        m_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(negedge clk);
        hold_rx = 1'b0;
        m_tready <= 1'b1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat (idle_len()) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int p;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: sticky mode 5, airmode mode 2, only modes below 10 selectable
    set_config(1'b0, 6'd5, 6'd2, 7'd10);
    put_eval(1'b0);                                   // empty table
    put_aux(5'd0, 12'd0);                             // clamps up to 900
    put_aux(5'd1, 12'd4095);                          // clamps down to 2099
    put_aux(5'd2, 12'd1000);
    put_aux(5'd15, 12'd2099);
    put_aux(5'd16, 12'd1234);                         // channel out of range
    put_aux(5'd31, 12'd4095);
    put_cond(5'd0, 6'd1, 4'd2, 6'd4, 6'd8, 1'b0, 6'd0);   // OR, in range
    put_cond(5'd1, 6'd3, 4'd2, 6'd4, 6'd8, 1'b1, 6'd0);   // AND, in range
    put_cond(5'd2, 6'd3, 4'd0, 6'd1, 6'd2, 1'b1, 6'd0);   // AND, out of range
    put_cond(5'd3, 6'd4, 4'd1, 6'd47, 6'd48, 1'b0, 6'd0); // top step
    put_cond(5'd4, 6'd6, 4'd2, 6'd8, 6'd8, 1'b0, 6'd0);   // unusable range
    put_cond(5'd5, 6'd2, 4'd0, 6'd1, 6'd0, 1'b0, 6'd1);   // airmode follows mode 1
    put_cond(5'd6, 6'd5, 4'd1, 6'd1, 6'd48, 1'b0, 6'd0);  // sticky condition
    put_cond(5'd19, 6'd12, 4'd2, 6'd0, 6'd48, 1'b0, 6'd0); // mode not selectable
    put_cond(5'd25, 6'd7, 4'd2, 6'd0, 6'd48, 1'b0, 6'd0);  // slot out of range
    put_cond(5'd7, 6'd0, 4'd0, 6'd0, 6'd0, 1'b1, 6'd0);    // non-empty by AND flag only
    send(OP_NOP, req_word(5'd31, 6'd63, 4'd15, 6'd63, 6'd63, 1'b1, 6'd63, 12'd4095, 1'b1));
    put_eval(1'b0);                                   // sticky held before boot
    put_eval(1'b1);                                   // range true: not yet seen off
    put_aux(5'd1, 12'd0);
    put_eval(1'b1);                                   // seen off now
    put_aux(5'd1, 12'd1500);
    put_eval(1'b1);                                   // sticky latches on
    put_aux(5'd1, 12'd0);
    put_eval(1'b1);                                   // and stays on
    put_cond(5'd0, 6'd0, 4'd0, 6'd0, 6'd0, 1'b0, 6'd0);   // empty slot 0 again
    put_eval(1'b0);

    for (p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0: set_config(1'b0, 6'd0, 6'd0, 7'd64);
        1: set_config(1'b1, 6'd63, 6'd63, 7'd0);
        default: set_config(1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)),
                            6'($urandom_range(0, 63)),
                            ($urandom_range(0, 1) != 0) ? 7'd64 : 7'($urandom_range(0, 64)));
      endcase
      mode_pool[0] = mode_check.sticky_id;
      mode_pool[1] = mode_check.air_id;
      mode_pool[2] = ($urandom_range(0, 1) != 0) ? 6'd0 : 6'($urandom_range(0, 63));
      mode_pool[3] = ($urandom_range(0, 1) != 0) ? 6'd63 : 6'($urandom_range(0, 63));
      mode_pool[4] = 6'($urandom_range(0, 63));
      mode_pool[5] = 6'($urandom_range(0, 15));
      aux_pool[0] = 4'($urandom_range(0, 15));
      aux_pool[1] = 4'($urandom_range(0, 15));
      aux_pool[2] = 4'($urandom_range(0, 15));
      aux_pool[3] = 4'($urandom_range(0, 15));
      calm = (p == 3 || p == 6);
      if (p == 2) begin
        // keep offering evaluates while the sink is held off
        hold_rx = 1'b1;
        repeat (30) put_eval(1'b1);
      end
      repeat (PHASE_ITEMS) random_item();
    end

    drain();
    if (fail_count == 0 && pending == 0)
      $display("** rc_mode_activation_evaluator_core: PASSED **");
    else
      $display("** rc_mode_activation_evaluator_core: FAILED **");
    $finish;
  end

  initial begin : watchdog
    #15_000_000;
    $display("** rc_mode_activation_evaluator_core: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire
